// ===== hdl/ddr_pkg.sv =====
// Shared types and constants for the dyadic divide-and-round block.
// Used by ddr_ctrl, ddr_datapath and dyadic_divide_round; depends on nothing.
package ddr_pkg;

    localparam int SIG_W      = 128;
    localparam int EXP_IN_W   = 17;
    localparam int EXP_OUT_W  = 19;
    localparam int EXP_W      = 20;
    localparam int PREC_W     = 8;
    localparam int IN_DATA_W  = 296;
    localparam int OUT_DATA_W = 152;

    // Input word layout.
    localparam int A_LO_OFS  = 0;
    localparam int A_HI_OFS  = 64;
    localparam int A_EXP_OFS = 128;
    localparam int A_NEG_OFS = 145;
    localparam int B_LO_OFS  = 146;
    localparam int B_HI_OFS  = 210;
    localparam int B_EXP_OFS = 274;
    localparam int B_NEG_OFS = 291;

    localparam logic [1:0] RND_NEAREST_EVEN = 2'd0;
    localparam logic [1:0] RND_DOWN         = 2'd1;
    localparam logic [1:0] RND_UP           = 2'd2;
    localparam logic [1:0] RND_ZERO         = 2'd3;

    localparam logic REG_ROUND_MODE = 1'b0;
    localparam logic REG_PRECISION  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_CMP,
        ST_DIV,
        ST_ROUND,
        ST_STRIP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic norm;
        logic cmp;
        logic div;
        logic round;
        logic strip;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic norm_done;
        logic cnt_zero;
        logic strip_done;
    } status_t;

endpackage

// ===== hdl/ddr_ctrl.sv =====
// Sequencing state machine for the divide-and-round block.
// Depends on ddr_pkg; drives ddr_datapath through cmd_t and reads status_t.
module ddr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_ready,
    input  ddr_pkg::status_t status,
    output ddr_pkg::cmd_t    cmd,
    output logic             in_ready,
    output logic             out_valid
);

    ddr_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ddr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddr_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.special ? ddr_pkg::ST_DONE : ddr_pkg::ST_NORM;
            end
            ddr_pkg::ST_NORM:
            begin
                if (status.norm_done)
                    state_next = ddr_pkg::ST_CMP;
            end
            ddr_pkg::ST_CMP:   state_next = ddr_pkg::ST_DIV;
            ddr_pkg::ST_DIV:
            begin
                if (status.cnt_zero)
                    state_next = ddr_pkg::ST_ROUND;
            end
            ddr_pkg::ST_ROUND: state_next = ddr_pkg::ST_STRIP;
            ddr_pkg::ST_STRIP:
            begin
                if (status.strip_done)
                    state_next = ddr_pkg::ST_DONE;
            end
            ddr_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = ddr_pkg::ST_IDLE;
            end
            default: state_next = ddr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ddr_pkg::ST_IDLE:  cmd.load  = in_valid;
            ddr_pkg::ST_NORM:  cmd.norm  = !status.norm_done;
            ddr_pkg::ST_CMP:   cmd.cmp   = 1'b1;
            ddr_pkg::ST_DIV:   cmd.div   = !status.cnt_zero;
            ddr_pkg::ST_ROUND: cmd.round = 1'b1;
            ddr_pkg::ST_STRIP: cmd.strip = !status.strip_done;
            ddr_pkg::ST_DONE:  cmd.publish = out_free;
            default:           cmd = '0;
        endcase
        out_valid_next = cmd.publish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

endmodule

// ===== hdl/ddr_datapath.sv =====
// Registers and arithmetic for normalization, restoring division, rounding and
// trailing-zero stripping. Depends on ddr_pkg; steered by ddr_ctrl commands.
module ddr_datapath (
    input  logic                              clk,
    input  ddr_pkg::cmd_t                     cmd,
    input  logic [ddr_pkg::IN_DATA_W-1:0]     in_data,
    input  logic [1:0]                        round_mode,
    input  logic [ddr_pkg::PREC_W-1:0]        precision,
    output ddr_pkg::status_t                  status,
    output logic [ddr_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                              out_dbz
);

    localparam int W = ddr_pkg::SIG_W;

    logic [W-1:0]                n_reg, n_next;
    logic [W-1:0]                d_reg, d_next;
    logic [W-1:0]                q_reg, q_next;
    logic signed [ddr_pkg::EXP_W-1:0] e_reg, e_next;
    logic                        neg_reg, neg_next;
    logic                        dbz_reg, dbz_next;
    logic [ddr_pkg::PREC_W-1:0]  cnt_reg, cnt_next;
    logic [ddr_pkg::OUT_DATA_W-1:0] out_reg;
    logic                        dbz_out_reg;

    logic [W-1:0] a_in, b_in;
    logic         a_zero, b_zero;
    logic signed [ddr_pkg::EXP_W-1:0] ea, eb;
    logic [ddr_pkg::PREC_W-1:0] p_eff;
    logic [W:0]   r2, r2_diff, cmp_diff;
    logic         r2_ge, n_lt_d, guard, rest, inc;
    logic [W:0]   q_inc;

    assign a_in   = {in_data[ddr_pkg::A_HI_OFS +: 64], in_data[ddr_pkg::A_LO_OFS +: 64]};
    assign b_in   = {in_data[ddr_pkg::B_HI_OFS +: 64], in_data[ddr_pkg::B_LO_OFS +: 64]};
    assign a_zero = (a_in == '0);
    assign b_zero = (b_in == '0);
    assign ea = ddr_pkg::EXP_W'($signed(in_data[ddr_pkg::A_EXP_OFS +: ddr_pkg::EXP_IN_W]));
    assign eb = ddr_pkg::EXP_W'($signed(in_data[ddr_pkg::B_EXP_OFS +: ddr_pkg::EXP_IN_W]));

    // Precision outside 1..128 is clamped.
    always_comb
    begin
        if (precision == '0)
            p_eff = ddr_pkg::PREC_W'(1);
        else if (precision > ddr_pkg::PREC_W'(W))
            p_eff = ddr_pkg::PREC_W'(W);
        else
            p_eff = precision;
    end

    // Shared 129-bit compare and subtract: doubled remainder against divisor.
    assign r2      = {n_reg, 1'b0};
    assign r2_diff = r2 - {1'b0, d_reg};
    assign r2_ge   = !r2_diff[W];
    assign n_lt_d  = (n_reg < d_reg);
    assign cmp_diff = n_lt_d ? r2_diff : ({1'b0, n_reg} - {1'b0, d_reg});

    assign guard = r2_ge;
    assign rest  = (r2 != {1'b0, d_reg}) && (n_reg != '0);
    assign q_inc = {1'b0, q_reg} + {{W{1'b0}}, 1'b1};

    always_comb
    begin
        if (!guard && !rest)
            inc = 1'b0;
        else
        begin
            case (round_mode)
                ddr_pkg::RND_DOWN:         inc = neg_reg;
                ddr_pkg::RND_UP:           inc = !neg_reg;
                ddr_pkg::RND_NEAREST_EVEN: inc = guard && (rest || q_reg[0]);
                default:                   inc = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        q_next   = q_reg;
        e_next   = e_reg;
        neg_next = neg_reg;
        dbz_next = dbz_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            n_next   = a_in;
            d_next   = b_in;
            q_next   = '0;
            dbz_next = b_zero;
            if (b_zero)
            begin
                e_next   = '0;
                neg_next = 1'b0;
            end
            else if (a_zero)
            begin
                e_next   = ea;
                neg_next = in_data[ddr_pkg::A_NEG_OFS];
            end
            else
            begin
                e_next   = ea - eb;
                neg_next = in_data[ddr_pkg::A_NEG_OFS] ^ in_data[ddr_pkg::B_NEG_OFS];
            end
        end
        else if (cmd.norm)
        begin
            // Both operands move toward a set top bit together; each shift
            // of the dividend lowers the exponent, each of the divisor raises it.
            e_next = e_reg;
            if (n_reg[W-1 -: 8] == '0)
            begin
                n_next = n_reg << 8;
                e_next = e_next - ddr_pkg::EXP_W'(8);
            end
            else if (!n_reg[W-1])
            begin
                n_next = n_reg << 1;
                e_next = e_next - ddr_pkg::EXP_W'(1);
            end
            if (d_reg[W-1 -: 8] == '0)
            begin
                d_next = d_reg << 8;
                e_next = e_next + ddr_pkg::EXP_W'(8);
            end
            else if (!d_reg[W-1])
            begin
                d_next = d_reg << 1;
                e_next = e_next + ddr_pkg::EXP_W'(1);
            end
        end
        else if (cmd.cmp)
        begin
            n_next   = cmp_diff[W-1:0];
            q_next   = {{(W-1){1'b0}}, 1'b1};
            cnt_next = p_eff - ddr_pkg::PREC_W'(1);
            e_next   = e_reg - ddr_pkg::EXP_W'(n_lt_d)
                       - ddr_pkg::EXP_W'(p_eff) + ddr_pkg::EXP_W'(1);
        end
        else if (cmd.div)
        begin
            n_next   = r2_ge ? r2_diff[W-1:0] : r2[W-1:0];
            q_next   = {q_reg[W-2:0], r2_ge};
            cnt_next = cnt_reg - ddr_pkg::PREC_W'(1);
        end
        else if (cmd.round)
        begin
            if (inc)
            begin
                if (q_inc[W])
                begin
                    q_next = {{(W-1){1'b0}}, 1'b1};
                    e_next = e_reg + ddr_pkg::EXP_W'(W);
                end
                else
                    q_next = q_inc[W-1:0];
            end
        end
        else if (cmd.strip)
        begin
            if (q_reg[7:0] == '0)
            begin
                q_next = q_reg >> 8;
                e_next = e_reg + ddr_pkg::EXP_W'(8);
            end
            else
            begin
                q_next = q_reg >> 1;
                e_next = e_reg + ddr_pkg::EXP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        e_reg   <= e_next;
        neg_reg <= neg_next;
        dbz_reg <= dbz_next;
        cnt_reg <= cnt_next;
        if (cmd.publish)
        begin
            out_reg     <= {4'b0, neg_reg, e_reg[ddr_pkg::EXP_OUT_W-1:0], q_reg};
            dbz_out_reg <= dbz_reg;
        end
    end

    assign status.special    = a_zero || b_zero;
    assign status.norm_done  = n_reg[W-1] && d_reg[W-1];
    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.strip_done = q_reg[0];
    assign out_data = out_reg;
    assign out_dbz  = dbz_out_reg;

endmodule

// ===== hdl/dyadic_divide_round.sv =====
// Top level of the dyadic divide-and-round block: stream ports, APB registers,
// controller and datapath. Depends on ddr_pkg, ddr_ctrl and ddr_datapath.
//
// One word in gives one word out. A zero divisor or zero dividend goes from
// acceptance straight to the done state and is published from there. Any other
// division is paced by the restoring divider, one quotient bit per cycle.
// Normalization shifts both operands at once, a byte and then a bit at a time.
// Trailing-zero stripping of the quotient shifts by a byte while its low byte
// is zero, else by a bit. The steps are normalization, the first compare, the
// division, rounding, stripping and publication from the done state. The
// default precision is 64. A stalled output holds the block in the done state.
// One division is in flight at a time; the finished result sits in an output
// register, so a new word may be accepted while it waits.
module dyadic_divide_round (
    input  logic         clk,
    input  logic         rst_n,
    // APB register port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, from bit 0: dividend_sig_low, dividend_sig_high, dividend_exp,
    // dividend_neg, divisor_sig_low, divisor_sig_high, divisor_exp, divisor_neg.
    input  logic [295:0] s_tdata,
    // Output stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, from bit 0: quot_sig_low, quot_sig_high, quot_exp, quot_neg.
    output logic [151:0] m_tdata,
    // m_tuser: divide_by_zero.
    output logic [0:0]   m_tuser
);

    logic [1:0]                 round_mode_reg;
    logic [ddr_pkg::PREC_W-1:0] precision_reg;
    logic                       wr_en;
    ddr_pkg::cmd_t              cmd;
    ddr_pkg::status_t           status;
    logic                       dbz;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_mode_reg <= ddr_pkg::RND_NEAREST_EVEN;
            precision_reg  <= 8'd64;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                ddr_pkg::REG_ROUND_MODE: round_mode_reg <= pwdata[1:0];
                ddr_pkg::REG_PRECISION:  precision_reg  <= pwdata[7:0];
                default:                 round_mode_reg <= round_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ddr_pkg::REG_ROUND_MODE: prdata = {30'b0, round_mode_reg};
            ddr_pkg::REG_PRECISION:  prdata = {24'b0, precision_reg};
            default:                 prdata = '0;
        endcase
    end

    ddr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    ddr_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .in_data    (s_tdata),
        .round_mode (round_mode_reg),
        .precision  (precision_reg),
        .status     (status),
        .out_data   (m_tdata),
        .out_dbz    (dbz)
    );

    assign m_tuser = dbz;

    // A divide-by-zero word carries an all-zero payload.
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("divide_by_zero result with nonzero payload");

    // A nonzero quotient always leaves with its trailing zeros stripped.
    a_odd_quot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[127:0] != '0) |-> m_tdata[0])
        else $error("nonzero quotient is not odd");

    // Only one division is in flight: after an accept the input is held off.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while a division is running");

endmodule

// ===== tb/sv/dyadic_divide_round_tb.sv =====
// Self-checking testbench for dyadic_divide_round: directed and random divisions
// over the stream ports, checked against a behavioral quotient predictor.
// Depends on ddr_pkg and dyadic_divide_round.
module dyadic_divide_round_tb;

    typedef struct {
        logic [127:0] sig;
        logic [16:0]  exp;
        logic         neg;
    } operand_t;

    typedef struct {
        logic [127:0] sig;
        logic [18:0]  exp;
        logic         neg;
        logic         dbz;
    } quotient_t;

    typedef struct {
        operand_t  a;
        operand_t  b;
        logic      known;
        quotient_t res;
    } div_row_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [295:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [0:0]   m_tuser;

    logic [1:0]   cur_round;
    logic [7:0]   cur_prec;
    quotient_t    expected_quotients[$];
    int           error_count;
    int           idle_cycles;
    int           stall_left;
    bit           stall_enable;

    dyadic_divide_round u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int sig_width(logic [127:0] v);
        for (int i = 127; i >= 0; i--)
        begin
            if (v[i])
                return i + 1;
        end
        return 0;
    endfunction

    // Restoring division to the configured precision, then rounding and stripping.
    function automatic quotient_t divide_round(operand_t a, operand_t b,
                                               logic [1:0] rmode, logic [7:0] prec);
        quotient_t    q;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] rem;
        logic [128:0] wide_rem;
        logic [128:0] quo;
        longint       e;
        int           p;
        int           tz;
        logic         top;
        logic         guard;
        logic         rest;
        logic         inc;
        int           c;
        q = '{sig: '0, exp: '0, neg: 1'b0, dbz: 1'b0};
        if (b.sig == 0)
        begin
            q.dbz = 1'b1;
            return q;
        end
        if (a.sig == 0)
        begin
            q.exp = {{2{a.exp[16]}}, a.exp};
            q.neg = a.neg;
            return q;
        end
        p = (prec == 0) ? 1 : int'(prec);
        if (p > 128)
            p = 128;
        num = a.sig << (128 - sig_width(a.sig));
        den = b.sig << (128 - sig_width(b.sig));
        e = longint'($signed(a.exp)) + sig_width(a.sig)
            - longint'($signed(b.exp)) - sig_width(b.sig);
        if (num >= den)
            rem = num - den;
        else
        begin
            e = e - 1;
            rem = (num << 1) - den;
        end
        quo = 129'd1;
        for (int i = 1; i < p; i++)
        begin
            top = rem[127];
            rem = rem << 1;
            quo = quo << 1;
            if (top || rem >= den)
            begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        wide_rem = {rem, 1'b0};
        c = (wide_rem > {1'b0, den}) ? 1 : (wide_rem == {1'b0, den}) ? 0 : -1;
        guard = c >= 0;
        rest = (c != 0) && (rem != 0);
        q.neg = a.neg ^ b.neg;
        if (!guard && !rest)
            inc = 1'b0;
        else if (rmode == ddr_pkg::RND_DOWN)
            inc = q.neg;
        else if (rmode == ddr_pkg::RND_UP)
            inc = !q.neg;
        else if (rmode == ddr_pkg::RND_NEAREST_EVEN)
            inc = guard && (rest || quo[0]);
        else
            inc = 1'b0;
        if (inc)
            quo = quo + 1;
        // A carry out of all 128 bits leaves a single one at bit 128.
        tz = 0;
        while (!quo[tz])
            tz++;
        quo = quo >> tz;
        q.sig = quo[127:0];
        e = e - p + 1 + tz;
        q.exp = e[18:0];
        return q;
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_mode(logic [1:0] rmode, logic [7:0] prec);
        // Registers change only with the block idle; the last result must be out.
        while (expected_quotients.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        apb_write({ddr_pkg::REG_ROUND_MODE, 2'b00}, {30'd0, rmode});
        apb_write({ddr_pkg::REG_PRECISION, 2'b00}, {24'd0, prec});
        cur_round = rmode;
        cur_prec = prec;
    endtask

    task automatic send_division(operand_t a, operand_t b, logic known, quotient_t res);
        int gap;
        if (stall_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {4'd0, b.neg, b.exp, b.sig[127:64], b.sig[63:0],
                    a.neg, a.exp, a.sig[127:64], a.sig[63:0]};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_quotients.push_back(known ? res : divide_round(a, b, cur_round, cur_prec));
    endtask

    function automatic logic [127:0] rand_sig();
        logic [127:0] v;
        int w;
        v = {$urandom, $urandom, $urandom, $urandom};
        w = $urandom_range(1, 128);
        case ($urandom_range(0, 3))
            0: v = v >> (128 - w);
            1: v = v & ~(128'd0) << $urandom_range(0, 127);
            2: v = (128'd1 << (w - 1)) | (v >> (129 - w));
            default: ;
        endcase
        if ($urandom_range(0, 40) == 0)
            v = 0;
        return v;
    endfunction

    function automatic operand_t rand_operand();
        operand_t o;
        o.sig = rand_sig();
        o.exp = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($signed($urandom_range(0, 400)) - 200);
        o.neg = $urandom_range(0, 1);
        return o;
    endfunction

    // Output side: random stall bursts, and a check against the oldest expectation.
    always @(posedge clk)
    begin
        quotient_t exp_q;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_quotients.size() == 0)
                begin
                    $error("quotient word with no expectation pending");
                    error_count++;
                end
                else
                begin
                    exp_q = expected_quotients.pop_front();
                    if (m_tdata[127:0] != exp_q.sig)
                    begin
                        $error("quot_sig expected %h actual %h", exp_q.sig, m_tdata[127:0]);
                        error_count++;
                    end
                    if (m_tdata[146:128] != exp_q.exp)
                    begin
                        $error("quot_exp expected %h actual %h", exp_q.exp, m_tdata[146:128]);
                        error_count++;
                    end
                    if (m_tdata[147] != exp_q.neg)
                    begin
                        $error("quot_neg expected %b actual %b", exp_q.neg, m_tdata[147]);
                        error_count++;
                    end
                    if (m_tuser[0] != exp_q.dbz)
                    begin
                        $error("divide_by_zero expected %b actual %b", exp_q.dbz, m_tuser[0]);
                        error_count++;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (!stall_enable)
            begin
                m_tready <= 1'b1;
                stall_left <= 0;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 8);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        div_row_t  rows[$];
        div_row_t  row;
        operand_t  one;
        operand_t  zero_op;
        operand_t  big;
        operand_t  x;
        operand_t  y;
        quotient_t none;

        error_count = 0;
        idle_cycles = 0;
        stall_left = 0;
        stall_enable = 1'b1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cur_round = ddr_pkg::RND_NEAREST_EVEN;
        cur_prec = 8'd64;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        one = '{sig: 128'd1, exp: 17'd0, neg: 1'b0};
        zero_op = '{sig: 128'd0, exp: 17'h10000, neg: 1'b1};
        big = '{sig: '1, exp: 17'h0FFFF, neg: 1'b1};
        none = '{sig: '0, exp: '0, neg: 1'b0, dbz: 1'b0};

        // Directed rows, at reset settings: nearest even, 64 bits.
        rows.push_back('{one, one, 1'b1, '{128'd1, 19'd0, 1'b0, 1'b0}});
        rows.push_back('{big, zero_op, 1'b1, '{128'd0, 19'd0, 1'b0, 1'b1}});
        rows.push_back('{zero_op, zero_op, 1'b1, '{128'd0, 19'd0, 1'b0, 1'b1}});
        rows.push_back('{zero_op, big, 1'b1, '{128'd0, 19'h70000, 1'b1, 1'b0}});
        rows.push_back('{big, big, 1'b1, '{128'd1, 19'd0, 1'b0, 1'b0}});
        rows.push_back('{big, one, 1'b0, none});
        rows.push_back('{one, big, 1'b0, none});
        rows.push_back('{'{128'd1, 17'h10000, 1'b0}, '{128'd3, 17'h0FFFF, 1'b1}, 1'b0, none});
        rows.push_back('{'{128'd2, 17'd5, 1'b1}, '{128'd3, 17'd0, 1'b1}, 1'b0, none});
        rows.push_back('{'{128'd10, 17'd0, 1'b0}, '{128'd7, 17'd0, 1'b0}, 1'b0, none});
        foreach (rows[i])
        begin
            row = rows[i];
            send_division(row.a, row.b, row.known, row.res);
        end
        s_tvalid <= 1'b0;

        // Extremes of precision with every rounding mode, including carry-out.
        for (int m = 0; m < 4; m++)
        begin
            set_mode(2'(m), (m == 0) ? 8'd128 : (m == 1) ? 8'd1 : (m == 2) ? 8'd255 : 8'd0);
            send_division(big, '{128'd3, 17'd1, 1'b0}, 1'b0, none);
            send_division('{128'd1, 17'd0, 1'b1}, '{128'd3, 17'd0, 1'b0}, 1'b0, none);
            send_division(big, '{'1 - 128'd1, 17'd0, 1'b0}, 1'b0, none);
            s_tvalid <= 1'b0;
        end

        // Random phases over settings; mostly small precisions for run time.
        for (int ph = 0; ph < 24; ph++)
        begin
            logic [7:0] prec;
            case ($urandom_range(0, 5))
                0: prec = 8'd128;
                1: prec = 8'($urandom_range(0, 255));
                default: prec = 8'($urandom_range(1, 40));
            endcase
            set_mode(2'($urandom_range(0, 3)), prec);
            if (ph >= 21)
                stall_enable = 1'b0;
            for (int k = 0; k < 75; k++)
            begin
                x = rand_operand();
                y = rand_operand();
                if ($urandom_range(0, 5) == 0)
                    y.sig = x.sig >> $urandom_range(0, 4);
                send_division(x, y, 1'b0, none);
            end
            s_tvalid <= 1'b0;
        end

        while (expected_quotients.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
